// File: rtl/mpq_pkg.sv
// Shared constants, types and codes of the min priority queue.
`default_nettype none
package mpq_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN1,
    S_MOVE_RD,
    S_MOVE_WR,
    S_SCAN2,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Candidate strobe into the shared comparator.
  typedef struct packed {
    logic clear;
    logic valid;
    idx_t idx;
  } cand_ctl_t;

  // Access request to the entry store.
  typedef struct packed {
    logic wr_en;
    idx_t wr_addr;
    logic rd_en;
    idx_t rd_addr;
  } store_req_t;

endpackage
`default_nettype wire

// File: rtl/mpq_store.sv
// Entry store: one write port and one read port with registered read data.
`default_nettype none
module mpq_store (
  input  logic                clk,
  input  mpq_pkg::store_req_t req,
  input  mpq_pkg::value_t     wr_data,
  output mpq_pkg::value_t     rd_data
);
  import mpq_pkg::*;

  value_t mem [CAPACITY];
  value_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: rtl/mpq_min_unit.sv
// Shared signed comparator that tracks the first-found smallest candidate.
`default_nettype none
module mpq_min_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  mpq_pkg::cand_ctl_t ctl,
  input  mpq_pkg::value_t    cand_val,
  output mpq_pkg::value_t    best_val,
  output mpq_pkg::idx_t      best_idx
);
  import mpq_pkg::*;

  logic   have_r, have_nxt;
  value_t best_val_r;
  idx_t   best_idx_r;
  logic   take;

  // A strict less-than keeps the lowest index among equal minima.
  assign take = ctl.valid && (ctl.clear || !have_r || (cand_val < best_val_r));

  always_comb begin
    have_nxt = have_r;
    if (ctl.valid) begin
      have_nxt = 1'b1;
    end else if (ctl.clear) begin
      have_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_val_r <= cand_val;
      best_idx_r <= ctl.idx;
    end
  end

  assign best_val = best_val_r;
  assign best_idx = best_idx_r;

endmodule
`default_nettype wire

// File: rtl/min_priority_queue.sv
// Top level: sequencer of the min priority queue over store and comparator.
// Enqueue and rejected items pass from S_IDLE through S_DONE back to S_IDLE.
// Dequeue makes two scans of the store through the single comparator, one word per
// cycle, with the move of the last word (S_MOVE_RD, S_MOVE_WR) between them.
// Items are accepted only in S_IDLE, so a new item waits until the last is done.
// The result is registered on leaving S_DONE; a held result stalls the sequencer.
// Synchronous active-low reset empties the queue; store contents are not cleared.
`default_nettype none
module min_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_front_value,
  output logic               out_is_empty,
  output logic [4:0]         out_entry_count
);
  import mpq_pkg::*;

  state_t     state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  cnt_t       addr_r, addr_nxt;
  status_t    stat_r, stat_nxt;
  logic       scan_rd_r, scan_rd_nxt;
  idx_t       rd_idx_r;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r;
  logic signed [31:0] out_front_r;
  logic       out_empty_r;
  logic [4:0] out_count_r;

  store_req_t req;
  value_t     wr_data;
  value_t     rd_data;
  cand_ctl_t  ctl;
  value_t     cand_val;
  value_t     best_val;
  idx_t       best_idx;
  value_t     front_w;
  cnt_t       last_w;
  value_t     in_fit;
  logic       accept;
  logic       full;
  logic       load_out;
  logic       issue;

  mpq_store u_store (
    .clk     (clk),
    .req     (req),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  mpq_min_unit u_min (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .cand_val (cand_val),
    .best_val (best_val),
    .best_idx (best_idx)
  );

  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign last_w   = count_r - CNT_W'(1);
  assign in_fit   = VALUE_BITS'(in_value);
  assign issue    = (addr_r < count_r);
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign front_w  = (count_r == '0) ? '0 : best_val;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func && (count_r != '0)) begin
            state_nxt = S_SCAN1;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN1: begin
        if (!issue && !scan_rd_r) begin
          state_nxt = S_MOVE_RD;
        end
      end
      S_MOVE_RD: state_nxt = S_MOVE_WR;
      S_MOVE_WR: state_nxt = S_SCAN2;
      S_SCAN2: begin
        if (!issue && !scan_rd_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    in_ready    = 1'b0;
    count_nxt   = count_r;
    addr_nxt    = addr_r;
    stat_nxt    = stat_r;
    scan_rd_nxt = 1'b0;
    req         = '0;
    wr_data     = rd_data;
    ctl         = '0;
    cand_val    = rd_data;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        addr_nxt = '0;
        if (accept) begin
          stat_nxt = STAT_DONE;
          if (!in_func) begin
            if (full) begin
              stat_nxt = STAT_FULL;
            end else begin
              // The new word joins the running minimum through the comparator.
              req.wr_en   = 1'b1;
              req.wr_addr = count_r[IDX_W-1:0];
              wr_data     = in_fit;
              ctl.valid   = 1'b1;
              ctl.clear   = (count_r == '0);
              ctl.idx     = count_r[IDX_W-1:0];
              cand_val    = in_fit;
              count_nxt   = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            stat_nxt = STAT_EMPTY;
          end else begin
            ctl.clear = 1'b1;
          end
        end
      end
      S_SCAN1, S_SCAN2: begin
        if (issue) begin
          req.rd_en   = 1'b1;
          req.rd_addr = addr_r[IDX_W-1:0];
          addr_nxt    = addr_r + CNT_W'(1);
          scan_rd_nxt = 1'b1;
        end
        ctl.valid = scan_rd_r;
        ctl.idx   = rd_idx_r;
      end
      S_MOVE_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = last_w[IDX_W-1:0];
      end
      S_MOVE_WR: begin
        // The last word fills the hole left by the minimum.
        req.wr_en   = 1'b1;
        req.wr_addr = best_idx;
        wr_data     = rd_data;
        count_nxt   = last_w;
        addr_nxt    = '0;
        ctl.clear   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      addr_r      <= '0;
      stat_r      <= STAT_DONE;
      scan_rd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      addr_r      <= addr_nxt;
      stat_r      <= stat_nxt;
      scan_rd_r   <= scan_rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= addr_r[IDX_W-1:0];
    if (load_out) begin
      out_status_r <= stat_r;
      out_front_r  <= 32'(front_w);
      out_empty_r  <= (count_r == '0);
      out_count_r  <= 5'(count_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_front_value = out_front_r;
  assign out_is_empty    = out_empty_r;
  assign out_entry_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_func && !full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("enqueue did not grow the count");

  a_hole_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE_WR) |-> (CNT_W'(best_idx) < count_r))
    else $error("removed entry beyond the stored entries");

  a_scan_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_rd_r |-> (state_r == S_SCAN1 || state_r == S_SCAN2))
    else $error("scan word arrived outside a scan");

endmodule
`default_nettype wire
